/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the radix converter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rca_pkg.sv */
// ----------------------------------------------------------------------------
// rca_pkg
// shared constants, types and helpers of the radix converter
// ----------------------------------------------------------------------------
package rca_pkg;

   localparam int VALUE_BITS_DEF = 31;
   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = 4;
   localparam int CHAR_BITS      = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 7'h30;
   localparam logic [CHAR_BITS-1:0] ASCII_A    = 7'h41;
   localparam logic [DIGIT_BITS-1:0] DEC_LIMIT = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // divider control and status
   typedef struct packed {
      logic start;
      logic load;
   } div_ctrl_type;

   typedef struct packed {
      logic                  done;
      logic [DIGIT_BITS-1:0] rem;
      logic                  quot_zero;
   } div_stat_type;

   // digit stack control
   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [DIGIT_BITS-1:0] digit;
   } stk_ctrl_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] d_ext;
      d_ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
      if (d < DEC_LIMIT) begin
         digit_to_ascii = ASCII_ZERO + d_ext;
      end else begin
         digit_to_ascii = ASCII_A + d_ext - {{(CHAR_BITS-DIGIT_BITS){1'b0}}, DEC_LIMIT};
      end
   endfunction

endpackage

/* design/rca_req_if.sv */
// ----------------------------------------------------------------------------
// rca_req_if
// input channel: value and radix with valid/ready
// ----------------------------------------------------------------------------
interface rca_req_if #(
   parameter int VALUE_BITS = rca_pkg::VALUE_BITS_DEF
);
   import rca_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [RADIX_BITS-1:0] radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

/* design/rca_rsp_if.sv */
// ----------------------------------------------------------------------------
// rca_rsp_if
// result channel: one ascii digit per word with valid/ready
// ----------------------------------------------------------------------------
interface rca_rsp_if;
   import rca_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] digit_char;
   logic                 last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

/* design/rca_divider.sv */
// ----------------------------------------------------------------------------
// rca_divider
// bit-serial restoring divider by a small radix, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rca_divider #(
   parameter int VALUE_BITS = rca_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rca_pkg::div_ctrl_type          ctrl,
   input  logic [VALUE_BITS-1:0]          value,
   input  logic [rca_pkg::RADIX_BITS-1:0] radix,
   output rca_pkg::div_stat_type          stat
);
   import rca_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] rad_ff, rad_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  nz_ff, nz_in;

   logic [RADIX_BITS-1:0] trial;
   logic [RADIX_BITS-1:0] diff;
   logic                  ge;
   logic                  last_step;

   // partial remainder with the next dividend bit shifted in
   assign trial     = {rem_ff, q_ff[VALUE_BITS-1]};
   assign ge        = (trial >= rad_ff);
   assign diff      = trial - rad_ff;
   assign last_step = (cnt_ff == CNT_BITS'(VALUE_BITS-1));

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      rad_in  = rad_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      nz_in   = nz_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         if (ctrl.load) begin
            q_in   = value;
            rad_in = radix;
         end
         rem_in = '0;
         cnt_in = '0;
         nz_in  = 1'b0;
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in   = {q_ff[VALUE_BITS-2:0], ge};
         rem_in = ge ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
         nz_in  = nz_ff | ge;
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (last_step) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      rad_ff <= rad_in;
      nz_ff  <= nz_in;
   end

   assign stat.done      = done_ff;
   assign stat.rem       = rem_ff;
   assign stat.quot_zero = ~nz_ff;

endmodule

/* design/rca_digit_stack.sv */
// ----------------------------------------------------------------------------
// rca_digit_stack
// last-in first-out shift register of digits, top entry at position zero
// ----------------------------------------------------------------------------
module rca_digit_stack #(
   parameter int VALUE_BITS = rca_pkg::VALUE_BITS_DEF,
   localparam int CNT_BITS  = $clog2(VALUE_BITS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rca_pkg::stk_ctrl_type          ctrl,
   output logic [rca_pkg::DIGIT_BITS-1:0] top,
   output logic [CNT_BITS-1:0]            count
);
   import rca_pkg::*;

   logic [DIGIT_BITS-1:0] stk_ff [VALUE_BITS];
   logic [CNT_BITS-1:0]   count_ff, count_in;

   // push moves every entry one place down, pop one place up
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         stk_ff[0] <= ctrl.digit;
         for (int i = 1; i < VALUE_BITS; i++) begin
            stk_ff[i] <= stk_ff[i-1];
         end
      end else if (ctrl.pop) begin
         for (int i = 0; i < VALUE_BITS - 1; i++) begin
            stk_ff[i] <= stk_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top   = stk_ff[0];
   assign count = count_ff;

endmodule

/* design/radix_converter_ascii.sv */
// timing: the first digit is offered once every division for the word is done,
//    and the rest follow one per cycle while rsp is ready
// acceptance: a new word is taken only at idle, after the last digit has left;
//    each digit takes one full pass of the bit-serial divider
// reset: synchronous, active high; returns to idle with an empty digit stack
// ----------------------------------------------------------------------------
// radix_converter_ascii
// converts a non-negative integer to uppercase ascii digits in radix 2..16,
// most significant digit first, last digit marked
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radix_converter_ascii #(
   parameter int VALUE_BITS = rca_pkg::VALUE_BITS_DEF
) (
   input logic    clock,
   input logic    reset,
   rca_req_if.sink   req_bus,
   rca_rsp_if.source rsp_bus
);
   import rca_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   state_type             state_ff, state_in;
   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;
   stk_ctrl_type          stk_ctrl;
   logic [DIGIT_BITS-1:0] stk_top;
   logic [CNT_BITS-1:0]   stk_count;
   logic [RADIX_BITS-1:0] rad_sat;
   logic                  req_take;
   logic                  rsp_take;
   logic                  div_finish;
   logic                  stk_room;
   logic                  div_started;

   // clamp the radix into 2..16
   always_comb begin
      if (req_bus.radix < RADIX_MIN) begin
         rad_sat = RADIX_MIN;
      end else if (req_bus.radix > RADIX_MAX) begin
         rad_sat = RADIX_MAX;
      end else begin
         rad_sat = req_bus.radix;
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid & req_bus.ready;
   assign rsp_take      = rsp_bus.valid & rsp_bus.ready;

   // stop dividing once the quotient is zero or the stack is about to fill
   assign div_finish = div_stat.quot_zero | (stk_count == CNT_BITS'(VALUE_BITS - 1));

   always_comb begin
      state_in       = state_ff;
      div_ctrl.start = 1'b0;
      div_ctrl.load  = 1'b0;
      stk_ctrl.push  = 1'b0;
      stk_ctrl.pop   = 1'b0;
      stk_ctrl.digit = div_stat.rem;
      case (state_ff)
         ST_IDLE: begin
            // load the new value and start the first division
            if (req_take) begin
               div_ctrl.start = 1'b1;
               div_ctrl.load  = 1'b1;
               state_in       = ST_DIV;
            end
         end
         ST_DIV: begin
            // each finished division pushes one remainder digit
            if (div_stat.done) begin
               stk_ctrl.push = 1'b1;
               if (div_finish) begin
                  state_in = ST_EMIT;
               end else begin
                  div_ctrl.start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            // digits leave most significant first straight off the stack top
            if (rsp_take) begin
               stk_ctrl.pop = 1'b1;
               if (stk_count == CNT_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   rca_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .value (req_bus.value),
      .radix (rad_sat),
      .stat  (div_stat)
   );

   rca_digit_stack #(
      .VALUE_BITS (VALUE_BITS)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .ctrl  (stk_ctrl),
      .top   (stk_top),
      .count (stk_count)
   );

   // output word comes from the stack top register
   assign rsp_bus.valid      = (state_ff == ST_EMIT);
   assign rsp_bus.digit_char = digit_to_ascii(stk_top);
   assign rsp_bus.last       = (stk_count == CNT_BITS'(1));

   // terms for the checks below
   assign stk_room    = (stk_count < CNT_BITS'(VALUE_BITS));
   assign div_started = (state_ff == ST_DIV) & ~div_stat.done;

   // an idle block holds no leftover digits
   `ASSERT_IMPL(a_idle_empty, clock, reset, req_bus.ready, stk_count == '0, "digits left at idle")
   // a word is only offered while a digit is stored
   `ASSERT_IMPL(a_emit_nonempty, clock, reset, rsp_bus.valid, stk_count != '0, "empty emit")
   // the stack never overflows
   `ASSERT_IMPL(a_push_room, clock, reset, stk_ctrl.push, stk_room, "stack overflow")
   // an accepted word starts the divider at once
   `ASSERT_NEXT(a_accept_div, clock, reset, req_take, div_started, "divider not started")

endmodule
